// ===== rtl/hrp_pkg.sv =====
// shared types, constants and character helpers for the http request header parser
package hrp_pkg;

  localparam int unsigned HeaderLimit  = 8192;
  localparam int unsigned PathMaxChars = 255;
  localparam int unsigned WordMaxChars = 15;
  localparam int unsigned HcWidth      = $clog2(HeaderLimit + 1);
  localparam int unsigned TpWidth      = $clog2(PathMaxChars + 2);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_REQLINE = 5'b00010,
    PH_HEADERS = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_CLOSE  = 2'd3
  } kind_e;

  localparam logic [3:0] R_NONE       = 4'd0;
  localparam logic [3:0] R_HDR_LARGE  = 4'd1;
  localparam logic [3:0] R_BUFFER     = 4'd2;
  localparam logic [3:0] R_LINE       = 4'd3;
  localparam logic [3:0] R_VERSION    = 4'd4;
  localparam logic [3:0] R_LENGTH     = 4'd5;
  localparam logic [3:0] R_CHUNKED    = 4'd6;
  localparam logic [3:0] R_METHOD     = 4'd7;
  localparam logic [3:0] R_EMPTY      = 4'd8;
  localparam logic [3:0] R_BODY_LARGE = 4'd9;
  localparam logic [3:0] R_TYPE       = 4'd10;
  localparam logic [3:0] R_STATS_BODY = 4'd11;
  localparam logic [3:0] R_NOT_FOUND  = 4'd12;
  localparam logic [3:0] R_EOF_HEADER = 4'd13;
  localparam logic [3:0] R_EOF_BODY   = 4'd14;

  localparam logic CFG_MAX_BODY    = 1'b0;
  localparam logic CFG_MAX_REQUEST = 1'b1;

  // value flag bits
  localparam int unsigned VF_COLON   = 0;
  localparam int unsigned VF_STARTED = 1;
  localparam int unsigned VF_BAD     = 2;
  localparam int unsigned VF_TRAIL   = 3;
  localparam int unsigned VF_DIGIT   = 4;
  localparam int unsigned VF_SEMI    = 5;
  localparam int unsigned VF_PLAIN   = 6;
  localparam int unsigned VF_CLOSE   = 7;

  // header kinds, one bit each
  localparam logic [3:0] HC_LENGTH = 4'b0001;
  localparam logic [3:0] HC_TYPE   = 4'b0010;
  localparam logic [3:0] HC_CONN   = 4'b0100;
  localparam logic [3:0] HC_TE     = 4'b1000;

  localparam logic [8*4-1:0]  TxtPost  = "POST";
  localparam logic [8*3-1:0]  TxtGet   = "GET";
  localparam logic [8*6-1:0]  TxtQuery = "/query";
  localparam logic [8*6-1:0]  TxtStats = "/stats";
  localparam logic [8*8-1:0]  TxtVer   = "HTTP/1.1";
  localparam logic [8*14-1:0] TxtCLen  = "content-length";
  localparam logic [8*12-1:0] TxtCType = "content-type";
  localparam logic [8*10-1:0] TxtConn  = "connection";
  localparam logic [8*17-1:0] TxtTe    = "transfer-encoding";
  localparam logic [8*10-1:0] TxtPlain = "text/plain";
  localparam logic [8*5-1:0]  TxtClose = "close";

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  body_byte;
    logic [9:0]  http_status;
    logic [3:0]  reason;
    logic        route;
    logic [31:0] content_length;
    logic        close_requested;
    logic        last;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic [9:0] status_of(input logic [3:0] r);
    case (r)
      R_NONE:       return 10'd0;
      R_METHOD:     return 10'd405;
      R_BODY_LARGE: return 10'd413;
      R_NOT_FOUND:  return 10'd404;
      default:      return 10'd400;
    endcase
  endfunction

  // request line word character, token t, candidate c, position p
  function automatic logic [7:0] word_char(input logic [1:0] t, input logic c,
                                           input logic [TpWidth-1:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (t)
      2'd0: if (!c) begin
        if (p < 4) ch = TxtPost[8*(3 - p[1:0]) +: 8];
      end else begin
        if (p < 3) ch = TxtGet[8*(2 - p[1:0]) +: 8];
      end
      2'd1: if (p < 6) begin
        ch = c ? TxtStats[8*(5 - p[2:0]) +: 8] : TxtQuery[8*(5 - p[2:0]) +: 8];
      end
      2'd2: if (!c && p < 8) ch = TxtVer[8*(7 - p[2:0]) +: 8];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [TpWidth-1:0] word_len(input logic [1:0] t, input logic c);
    case (t)
      2'd0:    return c ? TpWidth'(3) : TpWidth'(4);
      2'd1:    return TpWidth'(6);
      2'd2:    return c ? TpWidth'(0) : TpWidth'(8);
      default: return TpWidth'(0);
    endcase
  endfunction

  function automatic logic [4:0] field_len(input logic [1:0] i);
    case (i)
      2'd0:    return 5'd14;
      2'd1:    return 5'd12;
      2'd2:    return 5'd10;
      default: return 5'd17;
    endcase
  endfunction

  function automatic logic [7:0] field_char(input logic [1:0] i, input logic [4:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (i)
      2'd0:    if (p < 14) ch = TxtCLen[8*(13 - p) +: 8];
      2'd1:    if (p < 12) ch = TxtCType[8*(11 - p) +: 8];
      2'd2:    if (p < 10) ch = TxtConn[8*(9 - p) +: 8];
      default: if (p < 17) ch = TxtTe[8*(16 - p) +: 8];
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/http_request_header_parser.sv =====
// top level: configuration registers, parser core and result register
// Parses one item (request byte or close event) per clock cycle, at most one
// result per item. The core updates its running match state for each item and sits
// between the input handshake and a result register; in_ready_o stays high
// while the result register is empty or being drained, so back-to-back items
// sustain one item per cycle unless the output side stalls.
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [9:0]  http_status_o,
  output logic [3:0]  reason_o,
  output logic        route_o,
  output logic [31:0] content_length_o,
  output logic        close_requested_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic             accept;
  logic [31:0]      max_body_q, max_req_q;
  logic             out_valid_q;
  hrp_pkg::result_t res, res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= 32'd4095;
      max_req_q  <= 32'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hrp_pkg::CFG_MAX_BODY:    max_body_q <= cfg_data_i;
        hrp_pkg::CFG_MAX_REQUEST: max_req_q  <= cfg_data_i;
        default:                  max_req_q  <= max_req_q;
      endcase
    end
  end

  hrp_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .req_type_i          (req_type_i),
    .byte_value_i        (byte_value_i),
    .max_body_bytes_i    (max_body_q),
    .max_request_bytes_i (max_req_q),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && accept && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign body_byte_o       = res_q.body_byte;
  assign http_status_o     = res_q.http_status;
  assign reason_o          = res_q.reason;
  assign route_o           = res_q.route;
  assign content_length_o  = res_q.content_length;
  assign close_requested_o = res_q.close_requested;
  assign last_o            = res_q.last;

  accept_no_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == hrp_pkg::KIND_ACCEPT) |-> (reason_o == hrp_pkg::R_NONE))
    else $error("accepted item carries a reason");
  reject_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == hrp_pkg::KIND_REJECT) |-> (reason_o != hrp_pkg::R_NONE && last_o))
    else $error("reject without reason or last");
  stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_q)))
    else $error("result register changed under stall");

endmodule

// ===== rtl/hrp_core.sv =====
// request parsing state and its per-item next-state logic
module hrp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [7:0]       byte_value_i,
  input  logic [31:0]      max_body_bytes_i,
  input  logic [31:0]      max_request_bytes_i,
  output hrp_pkg::result_t res_o
);

  hrp_pkg::phase_e              phase_q, phase_d;
  logic [hrp_pkg::HcWidth-1:0]  hc_q, hc_d;
  logic [1:0]                   term_q, term_d;
  logic [1:0]                   tidx_q, tidx_d;
  logic [hrp_pkg::TpWidth-1:0]  tpos_q, tpos_d;
  logic [3:0]                   match_q, match_d;
  logic [4:0]                   npos_q, npos_d;
  logic [31:0]                  accum_q, accum_d;
  logic [7:0]                   vf_q, vf_d;
  logic [3:0]                   ferr_q, ferr_d;
  logic [31:0]                  rem_q, rem_d;
  logic [4:0]                   summ_q, summ_d;
  logic [31:0]                  clen_q, clen_d;

  // summary bits
  localparam int unsigned RlPost = 0;
  localparam int unsigned RlGet  = 1;
  localparam int unsigned RlQry  = 2;
  localparam int unsigned RlStat = 3;
  localparam int unsigned RlVer  = 4;

  always_comb begin
    logic                        do_clear, done, eol, bl;
    logic [7:0]                  b, lb;
    logic [3:0]                  kind, err;
    logic [35:0]                 t;
    logic [32:0]                 total;
    logic [hrp_pkg::TpWidth-1:0] lim;
    b = byte_value_i;
    lb = hrp_pkg::to_lower(b);
    bl = hrp_pkg::is_blank(b);
    eol = (b == 8'h0D) || (b == 8'h0A);
    do_clear = 1'b0;
    done = 1'b0;
    kind = 4'd0;
    err = hrp_pkg::R_NONE;
    t = '0;
    total = '0;
    lim = '0;
    phase_d = phase_q; hc_d = hc_q; term_d = term_q; tidx_d = tidx_q; tpos_d = tpos_q;
    match_d = match_q; npos_d = npos_q; accum_d = accum_q; vf_d = vf_q; ferr_d = ferr_q;
    rem_d = rem_q; summ_d = summ_q; clen_d = clen_q;
    res_o = '0;
    res_o.kind = hrp_pkg::KIND_BODY;

    if (accept_i) begin
      if (req_type_i) begin
        do_clear = 1'b1;
        res_o.last = 1'b1;
        if (phase_q == hrp_pkg::PH_IDLE && hc_q == '0) begin
          res_o.valid = 1'b1;
          res_o.kind = hrp_pkg::KIND_CLOSE;
        end else if (phase_q == hrp_pkg::PH_IDLE || phase_q == hrp_pkg::PH_REQLINE ||
                     phase_q == hrp_pkg::PH_HEADERS) begin
          res_o.valid = 1'b1;
          res_o.kind = hrp_pkg::KIND_REJECT;
          res_o.reason = hrp_pkg::R_EOF_HEADER;
        end else if (phase_q == hrp_pkg::PH_BODY) begin
          res_o.valid = 1'b1;
          res_o.kind = hrp_pkg::KIND_REJECT;
          res_o.reason = hrp_pkg::R_EOF_BODY;
        end
      end else if (phase_q == hrp_pkg::PH_BODY) begin
        res_o.valid = 1'b1;
        res_o.body_byte = b;
        res_o.last = (rem_q <= 32'd1);
        if (rem_q != '0) rem_d = rem_q - 32'd1;
        if (rem_d == '0) do_clear = 1'b1;
      end else if (phase_q != hrp_pkg::PH_DISCARD) begin
        hc_d = hc_q + 1'b1;
        if (b == 8'h0D) begin
          term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == 8'h0A) begin
          done = (term_q == 2'd3);
          term_d = (term_q == 2'd1) ? 2'd2 : 2'd0;
        end else begin
          term_d = 2'd0;
        end

        if (eol) begin
          if (phase_q == hrp_pkg::PH_REQLINE) begin
            // close the last token of the request line
            if (tpos_d != '0) begin
              if (tidx_d == 2'd0) begin
                if (match_d[0] && tpos_d == 4) summ_d[RlPost] = 1'b1;
                if (match_d[1] && tpos_d == 3) summ_d[RlGet] = 1'b1;
              end else if (tidx_d == 2'd1) begin
                if (match_d[0] && tpos_d == 6) summ_d[RlQry] = 1'b1;
                if (match_d[1] && tpos_d == 6) summ_d[RlStat] = 1'b1;
              end else if (tidx_d == 2'd2) begin
                if (match_d[0] && tpos_d == 8) summ_d[RlVer] = 1'b1;
              end
              if (tidx_d != 2'd3) tidx_d = tidx_d + 2'd1;
            end
            if (tidx_d != 2'd3) begin
              if (ferr_d == '0) ferr_d = hrp_pkg::R_LINE;
            end else if (!summ_d[RlVer]) begin
              if (ferr_d == '0) ferr_d = hrp_pkg::R_VERSION;
            end
            phase_d = hrp_pkg::PH_HEADERS;
          end else if (phase_q == hrp_pkg::PH_HEADERS) begin
            if (ferr_d == '0 && vf_d[hrp_pkg::VF_COLON]) begin
              if (match_d == hrp_pkg::HC_LENGTH) begin
                if (vf_d[hrp_pkg::VF_BAD] || !vf_d[hrp_pkg::VF_DIGIT]) ferr_d = hrp_pkg::R_LENGTH;
                else clen_d = accum_d;
              end else if (match_d == hrp_pkg::HC_TYPE) begin
                vf_d[hrp_pkg::VF_PLAIN] = !vf_d[hrp_pkg::VF_BAD] && (tpos_d >= 10);
              end else if (match_d == hrp_pkg::HC_CONN) begin
                if (!vf_d[hrp_pkg::VF_BAD] && tpos_d >= 5) vf_d[hrp_pkg::VF_CLOSE] = 1'b1;
              end
            end
          end
          if (phase_q == hrp_pkg::PH_REQLINE || phase_q == hrp_pkg::PH_HEADERS) begin
            tpos_d = '0;
            match_d = '0;
            npos_d = '0;
            accum_d = '0;
            vf_d = vf_d & 8'hC0;
          end
        end else if (phase_q == hrp_pkg::PH_HEADERS) begin
          if (ferr_q == '0) begin
            if (!vf_q[hrp_pkg::VF_COLON]) begin
              if (b == 8'h3A) begin
                for (int i = 3; i >= 0; i--) begin
                  if (match_q[i] && npos_q >= hrp_pkg::field_len(2'(i))) kind = 4'(1 << i);
                end
                if (kind == hrp_pkg::HC_TE) ferr_d = hrp_pkg::R_CHUNKED;
                match_d = kind;
                vf_d[hrp_pkg::VF_COLON] = 1'b1;
                tpos_d = '0;
                accum_d = '0;
              end else if (!(npos_q == '0 && bl)) begin
                if (npos_q == '0) match_d = 4'hF;
                for (int i = 0; i < 4; i++) begin
                  if (npos_q < hrp_pkg::field_len(2'(i)) &&
                      lb != hrp_pkg::field_char(2'(i), npos_q)) match_d[i] = 1'b0;
                end
                if (npos_q != 5'd31) npos_d = npos_q + 5'd1;
              end
            end else if (match_q != '0 && !vf_q[hrp_pkg::VF_BAD]) begin
              if (match_q == hrp_pkg::HC_LENGTH) begin
                if (bl) begin
                  if (vf_q[hrp_pkg::VF_STARTED]) vf_d[hrp_pkg::VF_TRAIL] = 1'b1;
                end else if (b >= 8'h30 && b <= 8'h39 && !vf_q[hrp_pkg::VF_TRAIL]) begin
                  t = {accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + 36'(b - 8'h30);
                  accum_d = (t[35:32] != '0) ? 32'hFFFF_FFFF : t[31:0];
                  vf_d[hrp_pkg::VF_STARTED] = 1'b1;
                  vf_d[hrp_pkg::VF_DIGIT] = 1'b1;
                end else begin
                  vf_d[hrp_pkg::VF_BAD] = 1'b1;
                end
              end else if (!(bl && !vf_q[hrp_pkg::VF_STARTED])) begin
                vf_d[hrp_pkg::VF_STARTED] = 1'b1;
                if (match_q == hrp_pkg::HC_TYPE) begin
                  if (vf_q[hrp_pkg::VF_SEMI]) begin
                    vf_d = vf_d;
                  end else if (vf_q[hrp_pkg::VF_TRAIL]) begin
                    if (!bl) vf_d[hrp_pkg::VF_BAD] = 1'b1;
                  end else begin
                    if (tpos_q < 10) begin
                      if (lb != hrp_pkg::TxtPlain[8*(9 - tpos_q[3:0]) +: 8])
                        vf_d[hrp_pkg::VF_BAD] = 1'b1;
                    end else if (b == 8'h3B) vf_d[hrp_pkg::VF_SEMI] = 1'b1;
                    else if (bl) vf_d[hrp_pkg::VF_TRAIL] = 1'b1;
                    else vf_d[hrp_pkg::VF_BAD] = 1'b1;
                    if (tpos_q <= 10) tpos_d = tpos_q + 1'b1;
                  end
                end else if (match_q == hrp_pkg::HC_CONN) begin
                  if (tpos_q < 5) begin
                    if (lb != hrp_pkg::TxtClose[8*(4 - tpos_q[2:0]) +: 8])
                      vf_d[hrp_pkg::VF_BAD] = 1'b1;
                    tpos_d = tpos_q + 1'b1;
                  end
                end
              end
            end
          end
        end else begin
          // request line character
          phase_d = hrp_pkg::PH_REQLINE;
          if (bl) begin
            if (tpos_q != '0) begin
              if (tidx_q == 2'd0) begin
                if (match_q[0] && tpos_q == 4) summ_d[RlPost] = 1'b1;
                if (match_q[1] && tpos_q == 3) summ_d[RlGet] = 1'b1;
              end else if (tidx_q == 2'd1) begin
                if (match_q[0] && tpos_q == 6) summ_d[RlQry] = 1'b1;
                if (match_q[1] && tpos_q == 6) summ_d[RlStat] = 1'b1;
              end else if (tidx_q == 2'd2) begin
                if (match_q[0] && tpos_q == 8) summ_d[RlVer] = 1'b1;
              end
              if (tidx_q != 2'd3) tidx_d = tidx_q + 2'd1;
              tpos_d = '0;
              match_d = '0;
            end
          end else if (tidx_q != 2'd3) begin
            if (tpos_q == '0) match_d = (tidx_q == 2'd2) ? 4'd1 : 4'd3;
            for (int c = 0; c < 2; c++) begin
              if (tpos_q >= hrp_pkg::word_len(tidx_q, 1'(c)) ||
                  hrp_pkg::word_char(tidx_q, 1'(c), tpos_q) != b) match_d[c] = 1'b0;
            end
            lim = (tidx_q == 2'd1) ? hrp_pkg::TpWidth'(hrp_pkg::PathMaxChars)
                                   : hrp_pkg::TpWidth'(hrp_pkg::WordMaxChars);
            if (tpos_q <= lim) tpos_d = tpos_q + 1'b1;
          end
        end

        if (done) begin
          err = ferr_d;
          if (phase_d == hrp_pkg::PH_IDLE) err = hrp_pkg::R_LINE;
          if (err == '0) begin
            if (summ_d[RlQry]) begin
              if (!summ_d[RlPost]) err = hrp_pkg::R_METHOD;
              else if (clen_d == '0) err = hrp_pkg::R_EMPTY;
              else if (clen_d > max_body_bytes_i) err = hrp_pkg::R_BODY_LARGE;
              else if (!vf_d[hrp_pkg::VF_PLAIN]) err = hrp_pkg::R_TYPE;
            end else if (summ_d[RlStat]) begin
              if (!summ_d[RlGet]) err = hrp_pkg::R_METHOD;
              else if (clen_d != '0) err = hrp_pkg::R_STATS_BODY;
            end else begin
              err = hrp_pkg::R_NOT_FOUND;
            end
          end
          total = 33'(hc_d) + {1'b0, clen_d};
          if (err == '0 && total > {1'b0, max_request_bytes_i}) err = hrp_pkg::R_BODY_LARGE;
          res_o.valid = 1'b1;
          if (err != '0) begin
            phase_d = hrp_pkg::PH_DISCARD;
            res_o.kind = hrp_pkg::KIND_REJECT;
            res_o.reason = err;
            res_o.last = 1'b1;
          end else begin
            res_o.kind = hrp_pkg::KIND_ACCEPT;
            res_o.route = summ_d[RlStat];
            res_o.content_length = clen_d;
            res_o.close_requested = vf_d[hrp_pkg::VF_CLOSE];
            res_o.last = (clen_d == '0);
            if (clen_d == '0) do_clear = 1'b1;
            else begin
              rem_d = clen_d;
              phase_d = hrp_pkg::PH_BODY;
            end
          end
        end else if (32'(hc_d) >= 32'(hrp_pkg::HeaderLimit)) begin
          phase_d = hrp_pkg::PH_DISCARD;
          res_o.valid = 1'b1;
          res_o.kind = hrp_pkg::KIND_REJECT;
          res_o.reason = hrp_pkg::R_HDR_LARGE;
          res_o.last = 1'b1;
        end else if (32'(hc_d) >= max_request_bytes_i) begin
          phase_d = hrp_pkg::PH_DISCARD;
          res_o.valid = 1'b1;
          res_o.kind = hrp_pkg::KIND_REJECT;
          res_o.reason = hrp_pkg::R_BUFFER;
          res_o.last = 1'b1;
        end
      end
    end
    res_o.http_status = hrp_pkg::status_of(res_o.reason);

    if (do_clear) begin
      phase_d = hrp_pkg::PH_IDLE; hc_d = '0; term_d = '0; tidx_d = '0; tpos_d = '0;
      match_d = '0; npos_d = '0; accum_d = '0; vf_d = '0; ferr_d = '0; rem_d = '0;
      summ_d = '0; clen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrp_pkg::PH_IDLE;
      hc_q <= '0; term_q <= '0; tidx_q <= '0; tpos_q <= '0; match_q <= '0;
      npos_q <= '0; accum_q <= '0; vf_q <= '0; ferr_q <= '0; rem_q <= '0;
      summ_q <= '0; clen_q <= '0;
    end else begin
      phase_q <= phase_d;
      hc_q <= hc_d; term_q <= term_d; tidx_q <= tidx_d; tpos_q <= tpos_d;
      match_q <= match_d; npos_q <= npos_d; accum_q <= accum_d; vf_q <= vf_d;
      ferr_q <= ferr_d; rem_q <= rem_d; summ_q <= summ_d; clen_q <= clen_d;
    end
  end

  body_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrp_pkg::PH_BODY) |-> (rem_q != '0))
    else $error("body phase with nothing left");
  header_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hc_q) <= 32'(hrp_pkg::HeaderLimit))
    else $error("header count past limit");
  idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrp_pkg::PH_IDLE) |-> (ferr_q == '0 || hc_q != '0))
    else $error("error recorded with no byte seen");

endmodule

// ===== test/http_request_header_parser_tb.sv =====
// testbench for the http request header parser: random and directed requests with a scoreboard
`timescale 1ns / 100ps

module http_request_header_parser_tb;
  import hrp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    kind_e       kind;
    bit [7:0]    body_byte;
    bit [9:0]    http_status;
    bit [3:0]    reason;
    bit          route;
    bit [31:0]   content_length;
    bit          close_requested;
    bit          last;
  } outcome_t;

  class parse_scoreboard;
    bit [31:0]   max_body;
    bit [31:0]   max_req;
    phase_e      ph;
    int unsigned hdr_cnt;
    bit [1:0]    term;
    int          tok_idx;
    int          tok_pos;
    bit [3:0]    cand;
    int          name_pos;
    bit [31:0]   accum;
    bit [7:0]    vf;
    bit [3:0]    first_err;
    bit [31:0]   body_left;
    bit [31:0]   committed;
    bit          post_ok, get_ok, query_ok, stats_ok, ver_ok;
    outcome_t    outcome_q[$];
    int          errors;

    function new();
      clear_request();
      max_body = 4095;
      max_req  = 16384;
      errors   = 0;
    endfunction

    function void clear_request();
      ph = PH_IDLE; hdr_cnt = 0; term = 0; tok_idx = 0; tok_pos = 0; cand = 0;
      name_pos = 0; accum = 0; vf = 0; first_err = R_NONE; body_left = 0;
      committed = 0;
      {post_ok, get_ok, query_ok, stats_ok, ver_ok} = '0;
    endfunction

    function void write_reg(bit idx, bit [31:0] val);
      if (idx == CFG_MAX_BODY) max_body = val;
      else max_req = val;
    endfunction

    function bit blank(bit [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0b || b == 8'h0c;
    endfunction

    function bit [7:0] lower(bit [7:0] b);
      return (b >= "A" && b <= "Z") ? b ^ 8'h20 : b;
    endfunction

    function string word_text(int t, int c);
      case (t)
        0:       return c ? "GET" : "POST";
        1:       return c ? "/stats" : "/query";
        default: return c ? "" : "HTTP/1.1";
      endcase
    endfunction

    function string field_name(int i);
      case (i)
        0:       return "content-length";
        1:       return "content-type";
        2:       return "connection";
        default: return "transfer-encoding";
      endcase
    endfunction

    function void note_err(bit [3:0] code);
      if (first_err == R_NONE) first_err = code;
    endfunction

    function void emit(kind_e k, bit [7:0] bb, bit [3:0] r, bit rt, bit [31:0] cl,
                       bit cr, bit lst);
      outcome_t o;
      o.kind = k; o.body_byte = bb; o.reason = r; o.route = rt;
      o.content_length = cl; o.close_requested = cr; o.last = lst;
      case (r)
        R_NONE:       o.http_status = 0;
        R_METHOD:     o.http_status = 405;
        R_BODY_LARGE: o.http_status = 413;
        R_NOT_FOUND:  o.http_status = 404;
        default:      o.http_status = 400;
      endcase
      outcome_q.push_back(o);
    endfunction

    function void new_line();
      tok_pos = 0; cand = 0; name_pos = 0; accum = 0;
      vf = vf & ((8'd1 << VF_PLAIN) | (8'd1 << VF_CLOSE));
    endfunction

    function void end_token();
      case (tok_idx)
        0: begin
          if (cand[0] && tok_pos == 4) post_ok = 1;
          if (cand[1] && tok_pos == 3) get_ok = 1;
        end
        1: begin
          if (cand[0] && tok_pos == 6) query_ok = 1;
          if (cand[1] && tok_pos == 6) stats_ok = 1;
        end
        2: if (cand[0] && tok_pos == 8) ver_ok = 1;
        default: ;
      endcase
      if (tok_idx < 3) tok_idx++;
      tok_pos = 0; cand = 0;
    endfunction

    function void line_char(bit [7:0] b);
      string w;
      int limit;
      if (blank(b)) begin
        if (tok_pos != 0) end_token();
        return;
      end
      if (tok_idx >= 3) return;
      if (tok_pos == 0) cand = (tok_idx == 2) ? 4'd1 : 4'd3;
      for (int c = 0; c < 2; c++) begin
        w = word_text(tok_idx, c);
        if (tok_pos >= w.len() || w[tok_pos] != b) cand[c] = 0;
      end
      limit = (tok_idx == 1) ? PathMaxChars : WordMaxChars;
      if (tok_pos <= limit) tok_pos++;
    endfunction

    function void end_request_line();
      if (tok_pos != 0) end_token();
      if (tok_idx < 3) note_err(R_LINE);
      else if (!ver_ok) note_err(R_VERSION);
      ph = PH_HEADERS;
      new_line();
    endfunction

    function void header_char(bit [7:0] b);
      bit [7:0] lb;
      bit [3:0] k;
      int p;
      string plain, cls, f;
      longint unsigned t;
      lb = lower(b);
      p = tok_pos;
      plain = "text/plain";
      cls = "close";
      if (first_err != R_NONE) return;
      if (!vf[VF_COLON]) begin
        if (b == ":") begin
          k = 0;
          for (int i = 0; i < 4; i++) begin
            f = field_name(i);
            if (k == 0 && cand[i] && name_pos >= f.len()) k = 4'd1 << i;
          end
          if (k == HC_TE) note_err(R_CHUNKED);
          cand = k; vf[VF_COLON] = 1; tok_pos = 0; accum = 0;
          return;
        end
        if (name_pos == 0 && blank(b)) return;
        if (name_pos == 0) cand = 4'hf;
        for (int i = 0; i < 4; i++) begin
          f = field_name(i);
          if (name_pos < f.len() && lb != f[name_pos]) cand[i] = 0;
        end
        if (name_pos < 31) name_pos++;
        return;
      end
      k = cand;
      if (k == 0 || vf[VF_BAD]) return;
      if (k == HC_LENGTH) begin
        if (blank(b)) begin
          if (vf[VF_STARTED]) vf[VF_TRAIL] = 1;
          return;
        end
        if (b >= "0" && b <= "9" && !vf[VF_TRAIL]) begin
          t = longint'(accum) * 10 + (b - "0");
          accum = (t > 64'hffff_ffff) ? 32'hffff_ffff : t[31:0];
          vf[VF_STARTED] = 1; vf[VF_DIGIT] = 1;
        end else begin
          vf[VF_BAD] = 1;
        end
        return;
      end
      if (blank(b) && !vf[VF_STARTED]) return;
      vf[VF_STARTED] = 1;
      if (k == HC_TYPE) begin
        if (vf[VF_SEMI]) return;
        if (vf[VF_TRAIL]) begin
          if (!blank(b)) vf[VF_BAD] = 1;
          return;
        end
        if (p < 10) begin
          if (lb != plain[p]) vf[VF_BAD] = 1;
        end else if (b == ";") vf[VF_SEMI] = 1;
        else if (blank(b)) vf[VF_TRAIL] = 1;
        else vf[VF_BAD] = 1;
        if (p <= 10) tok_pos++;
      end else if (k == HC_CONN && p < 5) begin
        if (lb != cls[p]) vf[VF_BAD] = 1;
        tok_pos++;
      end
    endfunction

    function void end_header_line();
      if (first_err == R_NONE && vf[VF_COLON]) begin
        if (cand == HC_LENGTH) begin
          if (vf[VF_BAD] || !vf[VF_DIGIT]) note_err(R_LENGTH);
          else committed = accum;
        end else if (cand == HC_TYPE) begin
          vf[VF_PLAIN] = !vf[VF_BAD] && tok_pos >= 10;
        end else if (cand == HC_CONN) begin
          if (!vf[VF_BAD] && tok_pos >= 5) vf[VF_CLOSE] = 1;
        end
      end
      new_line();
    endfunction

    function void decide();
      bit [3:0] err;
      bit [31:0] cl;
      cl = committed;
      err = (ph == PH_IDLE) ? R_LINE : first_err;
      if (err == R_NONE) begin
        if (query_ok) begin
          if (!post_ok) err = R_METHOD;
          else if (cl == 0) err = R_EMPTY;
          else if (cl > max_body) err = R_BODY_LARGE;
          else if (!vf[VF_PLAIN]) err = R_TYPE;
        end else if (stats_ok) begin
          if (!get_ok) err = R_METHOD;
          else if (cl != 0) err = R_STATS_BODY;
        end else begin
          err = R_NOT_FOUND;
        end
      end
      if (err == R_NONE && longint'(hdr_cnt) + longint'(cl) > longint'(max_req))
        err = R_BODY_LARGE;
      if (err != R_NONE) begin
        ph = PH_DISCARD;
        emit(KIND_REJECT, 0, err, 0, 0, 0, 1);
        return;
      end
      emit(KIND_ACCEPT, 0, R_NONE, stats_ok, cl, vf[VF_CLOSE], cl == 0);
      if (cl == 0) clear_request();
      else begin
        body_left = cl;
        ph = PH_BODY;
      end
    endfunction

    // one accepted input item: byte or peer close
    function void note_input(bit is_close, bit [7:0] b);
      phase_e old_ph;
      int unsigned old_cnt;
      bit done, eol;
      if (is_close) begin
        old_ph = ph;
        old_cnt = hdr_cnt;
        clear_request();
        if (old_ph == PH_IDLE && old_cnt == 0) emit(KIND_CLOSE, 0, R_NONE, 0, 0, 0, 1);
        else if (old_ph == PH_BODY) emit(KIND_REJECT, 0, R_EOF_BODY, 0, 0, 0, 1);
        else if (old_ph != PH_DISCARD) emit(KIND_REJECT, 0, R_EOF_HEADER, 0, 0, 0, 1);
        return;
      end
      if (ph == PH_BODY) begin
        emit(KIND_BODY, b, R_NONE, 0, 0, 0, body_left <= 1);
        if (body_left != 0) body_left--;
        if (body_left == 0) clear_request();
        return;
      end
      if (ph == PH_DISCARD) return;
      hdr_cnt++;
      done = 0;
      eol = (b == 8'h0d || b == 8'h0a);
      if (b == 8'h0d) term = (term == 2) ? 2'd3 : 2'd1;
      else if (b == 8'h0a) begin
        done = (term == 3);
        term = (term == 1) ? 2'd2 : 2'd0;
      end else term = 0;
      if (eol) begin
        if (ph == PH_REQLINE) end_request_line();
        else if (ph == PH_HEADERS) end_header_line();
      end else if (ph == PH_HEADERS) begin
        header_char(b);
      end else begin
        ph = PH_REQLINE;
        line_char(b);
      end
      if (done) decide();
      else if (hdr_cnt >= HeaderLimit) begin
        ph = PH_DISCARD;
        emit(KIND_REJECT, 0, R_HDR_LARGE, 0, 0, 0, 1);
      end else if (hdr_cnt >= max_req) begin
        ph = PH_DISCARD;
        emit(KIND_REJECT, 0, R_BUFFER, 0, 0, 0, 1);
      end
    endfunction

    function void check_result(bit [1:0] k, bit [7:0] bb, bit [9:0] st, bit [3:0] r,
                               bit rt, bit [31:0] cl, bit cr, bit lst);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        $error("result with no expectation: kind %0d reason %0d", k, r);
        errors++;
        return;
      end
      o = outcome_q.pop_front();
      if (k != o.kind) begin
        $error("kind: expected %0d, got %0d", o.kind, k); errors++;
      end
      if (bb != o.body_byte) begin
        $error("body_byte: expected %0h, got %0h", o.body_byte, bb); errors++;
      end
      if (st != o.http_status) begin
        $error("http_status: expected %0d, got %0d", o.http_status, st); errors++;
      end
      if (r != o.reason) begin
        $error("reason: expected %0d, got %0d", o.reason, r); errors++;
      end
      if (rt != o.route) begin
        $error("route: expected %0d, got %0d", o.route, rt); errors++;
      end
      if (cl != o.content_length) begin
        $error("content_length: expected %0d, got %0d", o.content_length, cl); errors++;
      end
      if (cr != o.close_requested) begin
        $error("close_requested: expected %0d, got %0d", o.close_requested, cr); errors++;
      end
      if (lst != o.last) begin
        $error("last: expected %0d, got %0d", o.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        req_type = 0;
  logic [7:0]  byte_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  kind;
  logic [7:0]  body_byte;
  logic [9:0]  http_status;
  logic [3:0]  reason;
  logic        route;
  logic [31:0] content_length;
  logic        close_requested;
  logic        last;
  logic        cfg_we = 0;
  logic        cfg_idx = 0;
  logic [31:0] cfg_data = 0;

  parse_scoreboard sb = new();
  bit [7:0]    pend_q[$];
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          quiet = 0;
  bit          long_hold = 0;

  http_request_header_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .byte_value_i      (byte_value),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .kind_o            (kind),
    .body_byte_o       (body_byte),
    .http_status_o     (http_status),
    .reason_o          (reason),
    .route_o           (route),
    .content_length_o  (content_length),
    .close_requested_o (close_requested),
    .last_o            (last),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_result(kind, body_byte, http_status, reason, route, content_length,
                      close_requested, last);
  end

  // receiver side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(negedge clk_i);
        long_hold = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(bit is_close, bit [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid   <= 1;
    req_type   <= is_close;
    byte_value <= b;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(is_close, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic flush_bytes();
    while (pend_q.size() != 0) send_item(0, pend_q.pop_front());
  endtask

  task automatic add_text(string s);
    foreach (s[i]) pend_q.push_back(s[i]);
  endtask

  task automatic send_text(string s, bit then_close);
    add_text(s);
    flush_bytes();
    if (then_close) send_item(1, $urandom_range(0, 255));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.outcome_q.size() != 0) @(negedge clk_i);
    // a trailing item may still be in flight with no result
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_regs(bit [31:0] body_max, bit [31:0] req_max);
    drain();
    cfg_we <= 1; cfg_idx <= CFG_MAX_BODY; cfg_data <= body_max;
    sb.write_reg(CFG_MAX_BODY, body_max);
    @(negedge clk_i);
    cfg_idx <= CFG_MAX_REQUEST; cfg_data <= req_max;
    sb.write_reg(CFG_MAX_REQUEST, req_max);
    @(negedge clk_i);
    cfg_we <= 0;
    @(negedge clk_i);
  endtask

  function automatic string mix_case(string s);
    string r;
    r = s;
    foreach (r[i])
      if (((r[i] >= "a" && r[i] <= "z") || (r[i] >= "A" && r[i] <= "Z")) &&
          $urandom_range(0, 3) == 0)
        r[i] = r[i] ^ 8'h20;
    return r;
  endfunction

  task automatic add_blanks(int lo, int hi);
    bit [7:0] sp[4] = '{8'h20, 8'h09, 8'h0b, 8'h0c};
    repeat ($urandom_range(lo, hi)) pend_q.push_back(sp[$urandom_range(0, 3)]);
  endtask

  task automatic add_eol();
    case ($urandom_range(0, 9))
      0:       add_text("\n");
      1:       add_text("\r");
      default: add_text("\r\n");
    endcase
  endtask

  task automatic add_junk(int lo, int hi, bit allow_eol);
    bit [7:0] b;
    repeat ($urandom_range(lo, hi)) begin
      b = $urandom_range(0, 255);
      if (!allow_eol && (b == 8'h0d || b == 8'h0a)) b = "z";
      pend_q.push_back(b);
    end
  endtask

  // mostly well-formed requests with random content and some breakage
  task automatic random_request();
    int route_pick;
    int cl;
    bit good_method;
    string meth;
    route_pick = $urandom_range(0, 19);
    good_method = $urandom_range(0, 9) != 0;
    cl = 0;
    if ($urandom_range(0, 9) == 0) add_eol();
    if (route_pick < 10) meth = good_method ? "POST" : "GET";
    else meth = good_method ? "GET" : "POST";
    case ($urandom_range(0, 19))
      0: meth = "post";
      1: meth = "PUT";
      2: meth = "POSTX";
      default: ;
    endcase
    add_blanks(0, 1);
    add_text(meth);
    add_blanks(1, 2);
    if (route_pick < 10) add_text("/query");
    else if (route_pick < 17) add_text("/stats");
    else if (route_pick == 17) add_text("/quer");
    else if (route_pick == 18) add_text("/statsx");
    else begin
      add_text("/");
      add_junk(1, 300, 0);
    end
    if ($urandom_range(0, 19) != 0) begin
      add_blanks(1, 2);
      case ($urandom_range(0, 14))
        0:       add_text("HTTP/1.0");
        1:       add_text("http/1.1");
        2:       add_text("HTTP/1.11");
        default: add_text("HTTP/1.1");
      endcase
      if ($urandom_range(0, 9) == 0) begin
        add_blanks(1, 1);
        add_text("extra");
      end
    end
    add_blanks(0, 1);
    if (route_pick < 10) cl = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
    else if ($urandom_range(0, 9) == 0) cl = $urandom_range(1, 3);
    if (cl != 0 || $urandom_range(0, 9) == 0) begin
      add_eol();
      add_text(mix_case("Content-Length"));
      add_blanks(0, 1);
      add_text(":");
      add_blanks(0, 2);
      case ($urandom_range(0, 24))
        0: begin add_text("1x"); cl = 0; end
        1: begin add_text("-2"); cl = 0; end
        2: cl = 0;
        3: begin add_text("99999999999"); cl = 0; end
        4: begin add_text("4 5"); cl = 0; end
        default: add_text($sformatf("%0d", cl));
      endcase
      add_blanks(0, 1);
    end
    if (route_pick < 10 && $urandom_range(0, 9) != 0) begin
      add_eol();
      add_text(mix_case("Content-Type:"));
      add_blanks(0, 2);
      case ($urandom_range(0, 9))
        0:       add_text("text/html");
        1:       add_text("text/plain; charset=utf-8");
        2:       add_text("text/plainx");
        3:       add_text("text/plain  x");
        default: add_text(mix_case("text/plain"));
      endcase
      add_blanks(0, 1);
    end
    repeat ($urandom_range(0, 3)) begin
      add_eol();
      case ($urandom_range(0, 9))
        0, 1: add_text(mix_case("Connection: close"));
        2:    add_text("Connection: keep-alive");
        3:    add_text("Transfer-Encoding: chunked");
        4:    add_junk(0, 12, 0);
        5:    add_text("Content-Lengthy: 7");
        default: begin
          add_text(mix_case("X-Trace:"));
          add_junk(0, 16, 0);
        end
      endcase
    end
    add_text("\r\n\r\n");
    add_junk(cl, cl, 1);
    flush_bytes();
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 19))
        0: begin
          add_junk(1, 20, 1);
          flush_bytes();
        end
        1: send_item(1, $urandom_range(0, 255));
        default: random_request();
      endcase
      // a rejected request holds the parser until the peer closes
      if (sb.ph == PH_DISCARD ? $urandom_range(0, 9) != 0 : $urandom_range(0, 7) == 0)
        send_item(1, $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed cases at reset settings
    send_item(1, 0);
    send_text("\r\n\r\n", 1);
    send_text("GET /stats HTTP/1.1\r\n\r\n", 0);
    send_text({"POST /query HTTP/1.1\r\nContent-Length: 3\r\nContent-Type: text/plain\r\n",
               "Connection: close\r\n\r\nabc"}, 0);
    send_text("GET /stats HTTP/1.0\r\n\r\n", 1);
    send_text("GET /stats\r\n\r\n", 1);
    send_text("POST /stats HTTP/1.1\r\n\r\n", 1);
    send_text("POST /query HTTP/1.1\r\n\r\n", 1);
    send_text("POST /query HTTP/1.1\r\ncontent-length: 5000\r\n\r\n", 1);
    send_text("POST /query HTTP/1.1\r\nContent-Length: 2\r\nContent-Type: text/html\r\n\r\n", 1);
    send_text("GET /stats HTTP/1.1\r\nContent-Length: 1\r\n\r\n", 1);
    send_text("GET /nope HTTP/1.1\r\n\r\n", 1);
    send_text("POST /query HTTP/1.1\r\nContent-Length: -1\r\n\r\n", 1);
    send_text("POST /query HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n", 1);
    send_text("GET /stats HTTP/1.1\r\nHost: x", 1);
    send_text({"POST /query HTTP/1.1\r\nContent-Length: 4\r\n",
               "Content-Type: TEXT/PLAIN;x\r\n\r\nab"}, 1);
    // header limit: no terminator ever arrives
    repeat (HeaderLimit) pend_q.push_back("a");
    flush_bytes();
    send_item(1, 0);
    random_phase(400);

    write_regs(1, 64);
    send_text("GET /stats HTTP/1.1\r\nX: 1234567890123456789012345678901234567890\r\n\r\n", 1);
    random_phase(300);

    write_regs(32'hffff_ffff, 32'hffff_ffff);
    send_text({"POST /query HTTP/1.1\r\nContent-Length: 99999999999\r\n",
               "Content-Type: text/plain\r\n\r\n"}, 1);
    long_hold = 1;
    random_phase(450);

    write_regs($urandom_range(1, 16), $urandom_range(64, 300));
    random_phase(350);

    write_regs(4095, 16384);
    random_phase(200);
    quiet = 1;
    random_phase(250);

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== http_request_header_parser.f =====
rtl/hrp_pkg.sv
rtl/hrp_core.sv
rtl/http_request_header_parser.sv
test/http_request_header_parser_tb.sv
